FILE: hw/rtl/bw4_pkg.sv
package bw4_pkg;

    // field widths
    localparam int CHAN_W    = 3;
    localparam int SAMPLE_W  = 24;
    localparam int COEF_W    = 32;
    localparam int FRAC_BITS = 27;

    // coefficient registers
    localparam int NUM_COEF  = 7;
    localparam int CFG_IDX_W = 3;

    // default channel count
    localparam int CHANNELS_DEF = 8;

    // request queue between front and engine, depth a power of two
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // datapath widths: products, running sums, shifted sum
    localparam int OPND_W = SAMPLE_W + 1;
    localparam int PROD_W = COEF_W + OPND_W;
    localparam int SUM1_W = PROD_W + 1;
    localparam int SUM2_W = PROD_W + 2;
    localparam int ACC_W  = PROD_W + 3;
    localparam int SH_W   = ACC_W - FRAC_BITS;

    // register index of each coefficient
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_A0,
        REG_A1,
        REG_A2,
        REG_B1,
        REG_B2,
        REG_B3,
        REG_B4
    } cfg_reg_t;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef coef_t coef_bank_t [NUM_COEF];

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // one request as classified by the front
    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        sample_t           sample;
        logic              in_range;
    } item_t;

endpackage

FILE: hw/rtl/bw4_front.sv
module bw4_front
    import bw4_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CHAN_W-1:0] s_chan_index,
    input  sample_t           s_sample_in,
    output logic              head_valid,
    output item_t             head_item,
    input  logic              head_pop
);

    item_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               push;
    item_t              new_item;

    // classify the request: channels past the configured count keep no state
    always_comb begin
        new_item.chan     = s_chan_index;
        new_item.sample   = s_sample_in;
        new_item.in_range = (int'(s_chan_index) < CHANNELS);
    end

    assign s_ready    = (count_reg != QCNT_W'(QDEPTH));
    assign push       = s_valid && s_ready;
    assign head_valid = (count_reg != '0);
    assign head_item  = q_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !head_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && head_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (head_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

FILE: hw/rtl/bw4_engine.sv
module bw4_engine
    import bw4_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  coef_bank_t        coef,
    input  logic              head_valid,
    input  item_t             head_item,
    output logic              head_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAN_W-1:0] m_chan_out,
    output sample_t           m_sample_out
);

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TAPS     = 4;

    // per-channel delay lines, index 0 is the most recent
    sample_t x_dly_reg [CHANNELS][TAPS];
    sample_t y_dly_reg [CHANNELS][TAPS];

    // stage 1: operands
    logic                     v1_reg, inr1_reg;
    logic [CHAN_W-1:0]        chan1_reg;
    logic signed [OPND_W-1:0] op_x04_reg, op_x13_reg;
    sample_t                  op_x2_reg;
    sample_t                  op_y_reg [TAPS];

    // stage 2: products
    logic                     v2_reg, inr2_reg;
    logic [CHAN_W-1:0]        chan2_reg;
    logic signed [PROD_W-1:0] prod_reg [NUM_COEF];
    logic signed [PROD_W-1:0] prod_next [NUM_COEF];

    // stage 3: pair sums
    logic                     v3_reg, inr3_reg;
    logic [CHAN_W-1:0]        chan3_reg;
    logic signed [SUM1_W-1:0] pair_reg [4];
    logic signed [SUM1_W-1:0] pair_next [4];

    // stage 4: half sums
    logic                     v4_reg, inr4_reg;
    logic [CHAN_W-1:0]        chan4_reg;
    logic signed [SUM2_W-1:0] half_reg [2];

    // result register
    logic                     m_valid_reg;
    logic [CHAN_W-1:0]        m_chan_reg;
    sample_t                  m_sample_reg;

    logic                       adv;
    logic                       hit;
    logic                       issue;
    logic [CH_IDX_W+CHAN_W-1:0] rd_ext;
    logic [CH_IDX_W+CHAN_W-1:0] wb_ext;
    logic [CH_IDX_W-1:0]        rd_idx;
    logic [CH_IDX_W-1:0]        wb_idx;
    sample_t                    x_rd [TAPS];
    sample_t                    y_rd [TAPS];
    logic signed [ACC_W-1:0]    acc;
    logic signed [SH_W-1:0]     acc_sh;
    logic [SH_W-SAMPLE_W:0]     acc_hi;
    sample_t                    y_sat;
    sample_t                    y_res;

    // whole pipeline moves when the result register can take a value
    assign adv = !m_valid_reg || m_ready;

    // a channel already in flight must write back its output before it is read again
    assign hit = (v1_reg && inr1_reg && chan1_reg == head_item.chan)
              || (v2_reg && inr2_reg && chan2_reg == head_item.chan)
              || (v3_reg && inr3_reg && chan3_reg == head_item.chan)
              || (v4_reg && inr4_reg && chan4_reg == head_item.chan);

    assign issue    = adv && head_valid && (!head_item.in_range || !hit);
    assign head_pop = issue;

    assign rd_ext = {{CH_IDX_W{1'b0}}, head_item.chan};
    assign rd_idx = rd_ext[CH_IDX_W-1:0];
    assign wb_ext = {{CH_IDX_W{1'b0}}, chan4_reg};
    assign wb_idx = wb_ext[CH_IDX_W-1:0];

    // state read for the issuing request
    always_comb begin
        for (int t = 0; t < TAPS; t++) begin
            x_rd[t] = head_item.in_range ? x_dly_reg[rd_idx][t] : '0;
            y_rd[t] = head_item.in_range ? y_dly_reg[rd_idx][t] : '0;
        end
    end

    // seven products off the stage 1 operands
    always_comb begin
        prod_next[REG_A0] = coef[REG_A0] * op_x04_reg;
        prod_next[REG_A1] = coef[REG_A1] * op_x13_reg;
        prod_next[REG_A2] = coef[REG_A2] * op_x2_reg;
        prod_next[REG_B1] = coef[REG_B1] * op_y_reg[0];
        prod_next[REG_B2] = coef[REG_B2] * op_y_reg[1];
        prod_next[REG_B3] = coef[REG_B3] * op_y_reg[2];
        prod_next[REG_B4] = coef[REG_B4] * op_y_reg[3];
    end

    // feedforward terms add, feedback terms subtract
    always_comb begin
        pair_next[0] = prod_reg[REG_A0] + prod_reg[REG_A1];
        pair_next[1] = prod_reg[REG_A2] - prod_reg[REG_B1];
        pair_next[2] = -prod_reg[REG_B2] - prod_reg[REG_B3];
        pair_next[3] = -prod_reg[REG_B4];
    end

    // final sum, floor shift and saturation
    always_comb begin
        acc    = half_reg[0] + half_reg[1];
        acc_sh = acc[ACC_W-1:FRAC_BITS];
        acc_hi = acc_sh[SH_W-1:SAMPLE_W-1];
        if (acc_hi == '0 || acc_hi == '1) begin
            y_sat = acc_sh[SAMPLE_W-1:0];
        end else if (acc_sh[SH_W-1]) begin
            y_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            y_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        y_res = inr4_reg ? y_sat : '0;
    end

    // pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg      <= issue;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            m_valid_reg <= v4_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            chan1_reg  <= head_item.chan;
            inr1_reg   <= head_item.in_range;
            op_x04_reg <= OPND_W'(head_item.sample) + OPND_W'(x_rd[3]);
            op_x13_reg <= OPND_W'(x_rd[0]) + OPND_W'(x_rd[2]);
            op_x2_reg  <= x_rd[1];
            for (int t = 0; t < TAPS; t++) begin
                op_y_reg[t] <= y_rd[t];
            end

            chan2_reg <= chan1_reg;
            inr2_reg  <= inr1_reg;
            prod_reg  <= prod_next;

            chan3_reg <= chan2_reg;
            inr3_reg  <= inr2_reg;
            pair_reg  <= pair_next;

            chan4_reg   <= chan3_reg;
            inr4_reg    <= inr3_reg;
            half_reg[0] <= pair_reg[0] + pair_reg[1];
            half_reg[1] <= pair_reg[2] + pair_reg[3];

            m_chan_reg   <= chan4_reg;
            m_sample_reg <= y_res;
        end
    end

    // input delay line shifts when the request issues
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                for (int t = 0; t < TAPS; t++) begin
                    x_dly_reg[c][t] <= '0;
                end
            end
        end else if (issue && head_item.in_range) begin
            x_dly_reg[rd_idx][0] <= head_item.sample;
            for (int t = 1; t < TAPS; t++) begin
                x_dly_reg[rd_idx][t] <= x_dly_reg[rd_idx][t-1];
            end
        end
    end

    // output delay line shifts when the result is formed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                for (int t = 0; t < TAPS; t++) begin
                    y_dly_reg[c][t] <= '0;
                end
            end
        end else if (adv && v4_reg && inr4_reg) begin
            y_dly_reg[wb_idx][0] <= y_sat;
            for (int t = 1; t < TAPS; t++) begin
                y_dly_reg[wb_idx][t] <= y_dly_reg[wb_idx][t-1];
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_chan_out   = m_chan_reg;
    assign m_sample_out = m_sample_reg;

endmodule

FILE: hw/rtl/butterworth4_lowpass_iir_core.sv
// channel   direction  handshake           payload
// s_        in         s_valid / s_ready   s_chan_index, s_sample_in
// m_        out        m_valid / m_ready   m_chan_out, m_sample_out
// cfg_      in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// a result passes from the queue through the operand, product and two adder-level
// registers in that order; shift and saturation then feed the result register.
// requests for different channels issue one per cycle while m_ready does not stall; a
// request whose channel is still in the four engine stages waits until that result
// writes the output delay line back, so requests of one channel never overlap in the engine.
// aresetn (synchronous) clears coefficients and all delay lines at once.
// a stalled m_ready freezes the engine; the two-entry queue takes requests until full.
module butterworth4_lowpass_iir_core
    import bw4_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CHAN_W-1:0]    s_chan_index,
    input  sample_t              s_sample_in,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CHAN_W-1:0]    m_chan_out,
    output sample_t              m_sample_out,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  coef_t                cfg_data
);

    coef_bank_t coef_reg;
    logic       head_valid;
    item_t      head_item;
    logic       head_pop;

    assign cfg_ready = 1'b1;

    // coefficient registers, writes past the last index are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_COEF; i++) begin
                coef_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_index <= REG_B4) begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    bw4_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_chan_index (s_chan_index),
        .s_sample_in  (s_sample_in),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .head_pop     (head_pop)
    );

    bw4_engine #(
        .CHANNELS (CHANNELS)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .coef         (coef_reg),
        .head_valid   (head_valid),
        .head_item    (head_item),
        .head_pop     (head_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_chan_out   (m_chan_out),
        .m_sample_out (m_sample_out)
    );

endmodule
